@@ design/lbr_pkg.sv @@
package lbr_pkg;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    typedef enum logic [4:0] {
        SLOPE_SHALLOW_POS = 5'b00001,
        SLOPE_SHALLOW_NEG = 5'b00010,
        SLOPE_STEEP_POS   = 5'b00100,
        SLOPE_STEEP_NEG   = 5'b01000,
        SLOPE_VERTICAL    = 5'b10000
    } t_slope;

endpackage

@@ design/lbr_out_buf.sv @@
module lbr_out_buf #(
    parameter int WIDTH = 21
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic             r_main_v;
    logic             r_skid_v;
    logic [WIDTH-1:0] r_main;
    logic [WIDTH-1:0] r_skid;
    logic             n_main_v;
    logic             n_skid_v;
    logic             pop;

    assign pop     = r_main_v & i_ready;
    assign o_full  = r_main_v & r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

    always_comb begin
        n_main_v = r_main_v;
        n_skid_v = r_skid_v;
        if (pop) begin
            n_main_v = r_skid_v | i_push;
            n_skid_v = r_skid_v & i_push;
        end else if (i_push) begin
            n_main_v = 1'b1;
            n_skid_v = r_main_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= n_main_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_v) begin
                r_main <= r_skid;
                if (i_push) begin
                    r_skid <= i_data;
                end
            end else if (i_push) begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            if (r_main_v) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

endmodule

@@ design/lbr_core.sv @@
module lbr_core #(
    parameter int COORD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_op,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic                  i_full,
    output logic                  o_push,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last
);

    localparam int C = COORD_BITS;
    localparam int D = COORD_BITS + 1;
    localparam int E = COORD_BITS + 3;

    // input register
    logic          r_in_v;
    lbr_pkg::t_op  r_op;
    logic [C-1:0]  r_sx, r_sy, r_ex, r_ey;

    // line state
    logic          r_active;
    lbr_pkg::t_slope r_slope;
    logic [C-1:0]  r_x, r_y;
    logic signed [E-1:0] r_err;
    logic signed [D-1:0] r_dx, r_dy;
    logic [D-1:0]  r_left;

    logic          fire;
    logic          accept;

    assign fire    = r_in_v & ~i_full;
    assign o_ready = ~r_in_v | ~i_full;
    assign accept  = i_valid & o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (accept) begin
            r_in_v <= 1'b1;
        end else if (fire) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= lbr_pkg::t_op'(i_op);
            r_sx <= i_start_x;
            r_sy <= i_start_y;
            r_ex <= i_end_x;
            r_ey <= i_end_y;
        end
    end

    // line setup
    logic                swap;
    logic [C-1:0]        x0, y0, x1, y1;
    logic signed [D-1:0] s_dx, s_dy, s_ndx, s_ndy, s_abs;
    lbr_pkg::t_slope     s_slope;
    logic signed [E-1:0] s_err;
    logic [D-1:0]        s_left;
    logic [C-1:0]        s_y;

    always_comb begin
        swap  = r_ex < r_sx;
        x0    = swap ? r_ex : r_sx;
        y0    = swap ? r_ey : r_sy;
        x1    = swap ? r_sx : r_ex;
        y1    = swap ? r_sy : r_ey;
        s_dx  = $signed({1'b0, x1} - {1'b0, x0});
        s_dy  = $signed({1'b0, y1} - {1'b0, y0});
        s_ndx = -s_dx;
        s_ndy = -s_dy;
        s_abs = s_dy[C] ? s_ndy : s_dy;
        s_y   = y0;
        if (s_dx == '0) begin
            s_slope = lbr_pkg::SLOPE_VERTICAL;
            s_err   = '0;
            s_left  = D'(s_abs) + D'(1);
            s_y     = s_dy[C] ? y1 : y0;
        end else if (s_dy >= 0 && s_dy <= s_dx) begin
            s_slope = lbr_pkg::SLOPE_SHALLOW_POS;
            s_err   = E'(s_ndx);
            s_left  = D'(s_dx) + D'(1);
        end else if (s_dy >= s_ndx && s_dy <= 0) begin
            s_slope = lbr_pkg::SLOPE_SHALLOW_NEG;
            s_err   = E'(s_dx);
            s_left  = D'(s_dx) + D'(1);
        end else if (s_dy > s_dx) begin
            s_slope = lbr_pkg::SLOPE_STEEP_POS;
            s_err   = E'(s_ndy);
            s_left  = D'(s_dy) + D'(1);
        end else begin
            s_slope = lbr_pkg::SLOPE_STEEP_NEG;
            s_err   = E'(s_dy);
            s_left  = D'(s_ndy) + D'(1);
        end
    end

    // step
    logic signed [E-1:0] dx2, dy2, e_x, e_y;
    logic [C-1:0]        n_x, n_y;
    logic signed [E-1:0] n_err;
    logic                emit;
    logic [D-1:0]        left_dec;

    assign dx2      = {r_dx[C], r_dx, 1'b0};
    assign dy2      = {r_dy[C], r_dy, 1'b0};
    assign e_x      = r_err + dy2;
    assign e_y      = r_err + dx2;
    assign emit     = fire & (r_op == lbr_pkg::OP_STEP) & r_active & (r_left != '0);
    assign left_dec = r_left - D'(1);

    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_err = r_err;
        unique case (r_slope)
            lbr_pkg::SLOPE_SHALLOW_POS: begin
                n_x   = r_x + C'(1);
                n_err = e_x;
                if (!e_x[E-1]) begin
                    n_y   = r_y + C'(1);
                    n_err = e_x - dx2;
                end
            end
            lbr_pkg::SLOPE_SHALLOW_NEG: begin
                n_x   = r_x + C'(1);
                n_err = e_x;
                if (e_x[E-1]) begin
                    n_y   = r_y - C'(1);
                    n_err = e_x + dx2;
                end
            end
            lbr_pkg::SLOPE_STEEP_POS: begin
                n_y   = r_y + C'(1);
                n_err = e_y;
                if (!e_y[E-1]) begin
                    n_x   = r_x + C'(1);
                    n_err = e_y - dy2;
                end
            end
            lbr_pkg::SLOPE_STEEP_NEG: begin
                n_y   = r_y - C'(1);
                n_err = e_y;
                if (!e_y[E-1] && e_y != '0) begin
                    n_x   = r_x + C'(1);
                    n_err = e_y + dy2;
                end
            end
            default: begin
                n_y = r_y + C'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_slope  <= lbr_pkg::SLOPE_SHALLOW_POS;
            r_x      <= '0;
            r_y      <= '0;
            r_err    <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
            r_left   <= '0;
        end else if (fire) begin
            if (r_op == lbr_pkg::OP_START) begin
                r_active <= 1'b1;
                r_slope  <= s_slope;
                r_x      <= x0;
                r_y      <= s_y;
                r_err    <= s_err;
                r_dx     <= s_dx;
                r_dy     <= s_dy;
                r_left   <= s_left;
            end else if (emit) begin
                r_active <= left_dec != '0;
                r_left   <= left_dec;
                r_x      <= n_x;
                r_y      <= n_y;
                r_err    <= n_err;
            end else begin
                r_active <= 1'b0;
            end
        end
    end

    assign o_push    = emit;
    assign o_pixel_x = r_x;
    assign o_pixel_y = r_y;
    assign o_last    = left_dec == '0;

`ifndef NO_ASSERTIONS
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("pixel pushed into full output buffer");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_last) |=> !r_active)
        else $error("line still active after final pixel");

    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_left != '0)
        else $error("active line with no pixels left");

    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_op == lbr_pkg::OP_START) |=> (r_active && r_left != '0))
        else $error("start word did not arm a line");
`endif

endmodule

@@ design/line_bresenham_rasterizer.sv @@
// Bresenham line rasterizer. A start word (tuser = 0) loads two endpoints and
// arms a line; each step word (tuser = 1) returns the next pixel of that line,
// with tlast on the final one. Start words and steps with no line in progress
// return nothing. One word is taken per clock while the output buffer has room
// and one pixel leaves per clock while the master is ready: each step is a
// single add and compare on the error term between the input register and the
// result register, and a pixel leaves via the output buffer register. A two-word
// output buffer keeps input flow going while a result waits on the master side.
module line_bresenham_rasterizer #(
    parameter int COORD_BITS = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // start_x, start_y, end_x, end_y
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // op
    input  logic i_s_axis_tuser,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // pixel_x, pixel_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    output logic o_m_axis_tlast
);

    localparam int C    = COORD_BITS;
    localparam int OTDW = ((2*COORD_BITS+7)/8)*8;
    localparam int BW   = 2*COORD_BITS + 1;

    logic          full;
    logic          push;
    logic [C-1:0]  px, py;
    logic          last;
    logic [BW-1:0] buf_out;

    lbr_core #(.COORD_BITS(COORD_BITS)) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_op      (i_s_axis_tuser),
        .i_start_x (i_s_axis_tdata[C-1:0]),
        .i_start_y (i_s_axis_tdata[2*C-1:C]),
        .i_end_x   (i_s_axis_tdata[3*C-1:2*C]),
        .i_end_y   (i_s_axis_tdata[4*C-1:3*C]),
        .i_full    (full),
        .o_push    (push),
        .o_pixel_x (px),
        .o_pixel_y (py),
        .o_last    (last)
    );

    lbr_out_buf #(.WIDTH(BW)) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({last, py, px}),
        .o_full  (full),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (buf_out)
    );

    assign o_m_axis_tdata = OTDW'(buf_out[2*C-1:0]);
    assign o_m_axis_tlast = buf_out[BW-1];

endmodule

@@ test/line_bresenham_rasterizer_test.sv @@
`timescale 1ns / 100ps

module line_bresenham_rasterizer_test;

    localparam int CB = 10;
    localparam int IN_W = ((4*CB+7)/8)*8;
    localparam int OUT_W = ((2*CB+7)/8)*8;
    localparam int CMAX = (1 << CB) - 1;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        lbr_pkg::t_op op;
        bit [CB-1:0]  sx;
        bit [CB-1:0]  sy;
        bit [CB-1:0]  ex;
        bit [CB-1:0]  ey;
    } t_line_word;

    typedef struct {
        bit [CB-1:0] x;
        bit [CB-1:0] y;
        bit          last;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_valid = 1'b0;
    logic [IN_W-1:0] s_data = '0;   // start_x, start_y, end_x, end_y
    logic s_user = 1'b0;            // op
    logic m_ready = 1'b0;
    logic o_s_axis_tready;
    logic o_m_axis_tvalid;
    logic [OUT_W-1:0] o_m_axis_tdata;   // pixel_x, pixel_y
    logic o_m_axis_tlast;

    t_line_word pending_words[$];
    t_pixel     pixel_due[$];

    // rasterizer state as predicted
    bit [CB-1:0]     trace_x = '0;
    bit [CB-1:0]     trace_y = '0;
    int              trace_err = 0;
    int              trace_dx = 0;
    int              trace_dy = 0;
    int              trace_left = 0;
    lbr_pkg::t_slope trace_slope = lbr_pkg::SLOPE_SHALLOW_POS;
    bit              trace_on = 1'b0;

    int  n_items = 0;
    int  items_taken = 0;
    int  lines_started = 0;
    int  pixels_checked = 0;
    int  errors = 0;
    bit  in_taken = 1'b0;
    int  hold_at = 32'h7fffffff;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    line_bresenham_rasterizer #(.COORD_BITS(CB)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    function automatic void note_error(string msg);
        errors++;
        if (errors <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic int idle_pct(bit sender);
        if (items_taken < n_items / 3) begin
            return sender ? 8 : 66;
        end else if (items_taken < 2 * n_items / 3) begin
            return sender ? 66 : 8;
        end
        return 0;
    endfunction

    function automatic void rasterize_word(t_line_word w);
        int x0;
        int y0;
        int x1;
        int y1;
        int t;
        t_pixel p;
        x0 = w.sx;
        y0 = w.sy;
        x1 = w.ex;
        y1 = w.ey;
        if (w.op == lbr_pkg::OP_START) begin
            lines_started++;
            if (x1 < x0) begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
            end
            trace_dx = x1 - x0;
            trace_dy = y1 - y0;
            trace_x = CB'(x0);
            trace_y = CB'(y0);
            if (trace_dx == 0) begin
                trace_slope = lbr_pkg::SLOPE_VERTICAL;
                trace_err = 0;
                trace_y = CB'((y0 <= y1) ? y0 : y1);
                trace_left = ((trace_dy < 0) ? -trace_dy : trace_dy) + 1;
            end else if (trace_dy >= 0 && trace_dy <= trace_dx) begin
                trace_slope = lbr_pkg::SLOPE_SHALLOW_POS;
                trace_err = -trace_dx;
                trace_left = trace_dx + 1;
            end else if (trace_dy >= -trace_dx && trace_dy <= 0) begin
                trace_slope = lbr_pkg::SLOPE_SHALLOW_NEG;
                trace_err = trace_dx;
                trace_left = trace_dx + 1;
            end else if (trace_dy > trace_dx) begin
                trace_slope = lbr_pkg::SLOPE_STEEP_POS;
                trace_err = -trace_dy;
                trace_left = trace_dy + 1;
            end else begin
                trace_slope = lbr_pkg::SLOPE_STEEP_NEG;
                trace_err = trace_dy;
                trace_left = -trace_dy + 1;
            end
            trace_on = 1'b1;
            return;
        end
        if (!trace_on || trace_left == 0) begin
            trace_on = 1'b0;
            return;
        end
        trace_left--;
        p.x = trace_x;
        p.y = trace_y;
        p.last = (trace_left == 0);
        pixel_due.push_back(p);
        if (trace_left == 0) begin
            trace_on = 1'b0;
        end
        case (trace_slope)
            lbr_pkg::SLOPE_SHALLOW_POS: begin
                trace_x = trace_x + 1'b1;
                trace_err += 2 * trace_dy;
                if (trace_err >= 0) begin
                    trace_y = trace_y + 1'b1;
                    trace_err -= 2 * trace_dx;
                end
            end
            lbr_pkg::SLOPE_SHALLOW_NEG: begin
                trace_x = trace_x + 1'b1;
                trace_err += 2 * trace_dy;
                if (trace_err < 0) begin
                    trace_y = trace_y - 1'b1;
                    trace_err += 2 * trace_dx;
                end
            end
            lbr_pkg::SLOPE_STEEP_POS: begin
                trace_y = trace_y + 1'b1;
                trace_err += 2 * trace_dx;
                if (trace_err >= 0) begin
                    trace_x = trace_x + 1'b1;
                    trace_err -= 2 * trace_dy;
                end
            end
            lbr_pkg::SLOPE_STEEP_NEG: begin
                trace_y = trace_y - 1'b1;
                trace_err += 2 * trace_dx;
                if (trace_err > 0) begin
                    trace_x = trace_x + 1'b1;
                    trace_err += 2 * trace_dy;
                end
            end
            default: begin
                trace_y = trace_y + 1'b1;
            end
        endcase
    endfunction

    function automatic bit [CB-1:0] any_coord();
        return CB'($urandom_range(CMAX));
    endfunction

    function automatic void add_word(lbr_pkg::t_op op, int sx, int sy, int ex, int ey);
        t_line_word w;
        w.op = op;
        w.sx = CB'(sx);
        w.sy = CB'(sy);
        w.ex = CB'(ex);
        w.ey = CB'(ey);
        pending_words.push_back(w);
    endfunction

    // start word followed by steps carrying junk coordinates
    function automatic void add_line(int sx, int sy, int ex, int ey, int steps);
        add_word(lbr_pkg::OP_START, sx, sy, ex, ey);
        repeat (steps) begin
            add_word(lbr_pkg::OP_STEP, any_coord(), any_coord(), any_coord(), any_coord());
        end
    endfunction

    function automatic int offset_coord(int base, int d);
        int v;
        v = base + d;
        if (v < 0 || v > CMAX) begin
            v = base - d;
        end
        return v;
    endfunction

    // driver
    always @(negedge i_clk) begin
        t_line_word w;
        if (i_rst_n && (!s_valid || in_taken)) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
                w = pending_words.pop_front();
                s_valid <= 1'b1;
                s_user <= w.op;
                s_data <= IN_W'({w.ey, w.ex, w.sy, w.sx});
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_ready <= i_rst_n && (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b0));
    end

    // one long receiver stall while words keep coming
    always @(negedge i_clk) begin
        if (!hold_done && items_taken >= hold_at) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_line_word w;
        t_pixel p;
        in_taken <= i_rst_n && s_valid && o_s_axis_tready;
        if (i_rst_n) begin
            if (s_valid && o_s_axis_tready) begin
                w.op = lbr_pkg::t_op'(s_user);
                w.sx = s_data[CB-1:0];
                w.sy = s_data[2*CB-1:CB];
                w.ex = s_data[3*CB-1:2*CB];
                w.ey = s_data[4*CB-1:3*CB];
                rasterize_word(w);
                items_taken++;
            end
            if (o_m_axis_tvalid && m_ready) begin
                if (pixel_due.size() == 0) begin
                    note_error($sformatf("%0t: unexpected pixel x=%0d y=%0d last=%0b", $realtime,
                        o_m_axis_tdata[CB-1:0], o_m_axis_tdata[2*CB-1:CB], o_m_axis_tlast));
                end else begin
                    p = pixel_due.pop_front();
                    pixels_checked++;
                    if (o_m_axis_tdata[CB-1:0] != p.x || o_m_axis_tdata[2*CB-1:CB] != p.y
                            || o_m_axis_tlast != p.last) begin
                        note_error($sformatf(
                            "%0t: pixel exp x=%0d y=%0d last=%0b got x=%0d y=%0d last=%0b",
                            $realtime, p.x, p.y, p.last, o_m_axis_tdata[CB-1:0],
                            o_m_axis_tdata[2*CB-1:CB], o_m_axis_tlast));
                    end
                end
            end
        end
    end

    initial begin
        int dx;
        int dy;
        int mag;
        int sx;
        int sy;
        int pix;
        int steps;
        int waited;

        // directed
        add_word(lbr_pkg::OP_STEP, CMAX, CMAX, CMAX, CMAX);  // step with no line
        add_line(0, 0, 0, 0, 2);                        // single pixel, then idle step
        add_line(CMAX, CMAX, CMAX-2, CMAX-1, 3);        // swapped, shallow rising at the edge
        add_line(0, 1, 2, 0, 3);                        // shallow falling
        add_line(5, 0, 6, 3, 2);                        // steep rising, dropped by next start
        add_line(CMAX-1, CMAX, CMAX, CMAX-3, 4);        // steep falling
        add_line(CMAX/2+1, CMAX, CMAX/2+1, CMAX-2, 4);  // vertical downward, y wraps after end

        // random
        while (pending_words.size() < 1250) begin
            if ($urandom_range(99) < 85) begin
                mag = ($urandom_range(99) < 3) ? 150 : 9;
                dx = $urandom_range(2*mag) - mag;
                dy = $urandom_range(2*mag) - mag;
                case ($urandom_range(9))
                    0: dy = dx;
                    1: dy = -dx;
                    2: dx = 0;
                    3: dy = ($urandom_range(1) != 0) ? 0 : dy;
                    default: ;
                endcase
                sx = $urandom_range(CMAX);
                sy = $urandom_range(CMAX);
                pix = ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ?
                       (dx < 0 ? -dx : dx) : (dy < 0 ? -dy : dy)) + 1;
                if ($urandom_range(9) == 0) begin
                    steps = $urandom_range(pix, 1);
                end else begin
                    steps = pix + $urandom_range(1);
                end
                add_line(sx, sy, offset_coord(sx, dx), offset_coord(sy, dy), steps);
            end else begin
                add_word(lbr_pkg::t_op'($urandom_range(1)), any_coord(), any_coord(),
                         any_coord(), any_coord());
            end
        end
        n_items = pending_words.size();
        hold_at = 2 * n_items / 3 + 10;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (items_taken < n_items) @(negedge i_clk);
        waited = 0;
        while (pixel_due.size() != 0 && waited < 5000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (20) @(negedge i_clk);
        if (pixel_due.size() != 0) begin
            note_error($sformatf("%0d pixels never arrived", pixel_due.size()));
        end

        $display("%0d words sent, %0d lines started, %0d pixels checked, %0d errors",
                 items_taken, lines_started, pixels_checked, errors);
        $display("idle mixes on both sides plus a %0d-cycle output stall", HOLD_CYCLES);
        if (errors == 0) begin
            $display("line_bresenham_rasterizer: match");
        end else begin
            $display("line_bresenham_rasterizer: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("line_bresenham_rasterizer: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
design/lbr_pkg.sv
design/lbr_out_buf.sv
design/lbr_core.sv
design/line_bresenham_rasterizer.sv
test/line_bresenham_rasterizer_test.sv
